FILE: sv/tsm_pkg.sv
`timescale 1ns / 1ps

package tsm_pkg;

  localparam int TSM_QUEUE_DEPTH = 16;
  localparam int CMD_DEPTH = 2;
  localparam int CMD_AW = 1;

  localparam logic [1:0] ACT_PUSH_A = 2'd0;
  localparam logic [1:0] ACT_PUSH_B = 2'd1;
  localparam logic [1:0] ACT_END_A  = 2'd2;
  localparam logic [1:0] ACT_END_B  = 2'd3;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_ENDED = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
  } tsm_in_t;

  typedef struct packed {
    logic signed [31:0] value_res;
    logic               has_value;
    logic               last;
    logic [1:0]         error;
  } tsm_out_t;

  typedef struct packed {
    logic               is_push;
    logic               side;
    logic signed [31:0] value;
  } tsm_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MERGE_RD,
    ST_MERGE_CMP,
    ST_DRAIN_RD,
    ST_DRAIN_EMIT
  } tsm_state_t;

  function automatic tsm_out_t mk_out(logic signed [31:0] v, logic hv, logic lst,
                                      logic [1:0] err);
    tsm_out_t o;
    o.value_res = v;
    o.has_value = hv;
    o.last      = lst;
    o.error     = err;
    return o;
  endfunction

endpackage

FILE: sv/tsm_front.sv
`timescale 1ns / 1ps

module tsm_front import tsm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  tsm_in_t  in_item,
  output tsm_cmd_t cmd_o,
  output logic     cmd_valid,
  input  logic     cmd_take
);

  tsm_cmd_t           q_r [CMD_DEPTH];
  logic [CMD_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [CMD_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CMD_AW:0]    cnt_r, cnt_nxt;
  logic               accept;
  tsm_cmd_t           cls;

  always_comb begin
    cls.is_push = in_item.action inside {ACT_PUSH_A, ACT_PUSH_B};
    cls.side    = in_item.action inside {ACT_PUSH_B, ACT_END_B};
    cls.value   = in_item.value;
  end

  assign in_full   = (cnt_r == (CMD_AW+1)'(CMD_DEPTH));
  assign accept    = in_push && !in_full;
  assign cmd_valid = (cnt_r != '0);
  assign cmd_o     = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = accept ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = cmd_take ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (accept && !cmd_take) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!accept && cmd_take) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

FILE: sv/tsm_back.sv
`timescale 1ns / 1ps

module tsm_back import tsm_pkg::*; #(
  parameter int QUEUE_DEPTH = TSM_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  tsm_cmd_t cmd_i,
  input  logic     cmd_valid,
  output logic     cmd_take,
  output logic     out_empty,
  input  logic     out_pop,
  output tsm_out_t out_item
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [31:0]        mem [QUEUE_DEPTH];
  logic signed [31:0] rd_data_r;

  tsm_state_t  state_r, state_nxt;
  tsm_cmd_t    cmd_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic        side_r, side_nxt;
  logic        a_done_r, a_done_nxt;
  logic        b_done_r, b_done_nxt;
  logic        drain_last_r;
  tsm_out_t    out_r;
  logic        out_valid_r;

  tsm_cmd_t    cur;
  logic        cur_done, oth_done, q_empty, q_full, slot_free, head_first, last_one;
  logic [CW:0] wsum;
  logic [AW-1:0] waddr;

  logic        d_emit, d_store, d_set, d_clear, d_last;
  tsm_out_t    d_item;
  tsm_state_t  d_next;

  logic        emit, store, pop, set_done, clear_all;
  tsm_out_t    emit_item;

  assign cur        = (state_r == ST_IDLE) ? cmd_i : cmd_r;
  assign cur_done   = cur.side ? b_done_r : a_done_r;
  assign oth_done   = cur.side ? a_done_r : b_done_r;
  assign q_empty    = (count_r == '0);
  assign q_full     = (count_r == CW'(QUEUE_DEPTH));
  assign last_one   = (count_r == CW'(1));
  assign slot_free  = !out_valid_r || out_pop;
  assign head_first = side_r ? (rd_data_r <= cur.value) : (rd_data_r < cur.value);
  assign wsum       = (CW+1)'(head_r) + (CW+1)'(count_r);
  assign waddr      = (wsum >= (CW+1)'(QUEUE_DEPTH)) ? AW'(wsum - (CW+1)'(QUEUE_DEPTH))
                                                     : AW'(wsum);

  always_comb begin
    d_emit  = 1'b0;
    d_item  = mk_out('0, 1'b0, 1'b0, ERR_NONE);
    d_store = 1'b0;
    d_set   = 1'b0;
    d_clear = 1'b0;
    d_last  = 1'b0;
    d_next  = ST_IDLE;
    if (cur.is_push) begin
      if (cur_done) begin
        d_emit = 1'b1;
        d_item = mk_out('0, 1'b0, 1'b0, ERR_ENDED);
      end else if (q_empty) begin
        if (oth_done) begin
          d_emit = 1'b1;
          d_item = mk_out(cur.value, 1'b1, 1'b0, ERR_NONE);
        end else begin
          d_store = 1'b1;
        end
      end else if (side_r == cur.side) begin
        if (q_full) begin
          d_emit = 1'b1;
          d_item = mk_out('0, 1'b0, 1'b0, ERR_FULL);
        end else begin
          d_store = 1'b1;
        end
      end else begin
        d_next = ST_MERGE_RD;
      end
    end else if (!cur_done) begin
      d_set = 1'b1;
      if (oth_done) begin
        if (q_empty) begin
          d_emit  = 1'b1;
          d_item  = mk_out('0, 1'b0, 1'b1, ERR_NONE);
          d_clear = 1'b1;
        end else begin
          d_next = ST_DRAIN_RD;
          d_last = 1'b1;
        end
      end else if (!q_empty && side_r != cur.side) begin
        d_next = ST_DRAIN_RD;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && (!d_emit || slot_free)) state_nxt = d_next;
      end
      ST_MERGE_RD: begin
        if (!q_empty) begin
          state_nxt = ST_MERGE_CMP;
        end else if (!oth_done || slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MERGE_CMP: begin
        if (slot_free) state_nxt = head_first ? ST_MERGE_RD : ST_IDLE;
      end
      ST_DRAIN_RD: state_nxt = ST_DRAIN_EMIT;
      ST_DRAIN_EMIT: begin
        if (slot_free) state_nxt = last_one ? ST_IDLE : ST_DRAIN_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_take  = 1'b0;
    emit      = 1'b0;
    emit_item = mk_out('0, 1'b0, 1'b0, ERR_NONE);
    store     = 1'b0;
    pop       = 1'b0;
    set_done  = 1'b0;
    clear_all = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd_take  = cmd_valid && (!d_emit || slot_free);
        emit      = cmd_take && d_emit;
        emit_item = d_item;
        store     = cmd_take && d_store;
        set_done  = cmd_take && d_set;
        clear_all = cmd_take && d_clear;
      end
      ST_MERGE_RD: begin
        if (q_empty) begin
          if (oth_done) begin
            emit      = slot_free;
            emit_item = mk_out(cur.value, 1'b1, 1'b0, ERR_NONE);
          end else begin
            store = 1'b1;
          end
        end
      end
      ST_MERGE_CMP: begin
        if (slot_free) begin
          emit = 1'b1;
          if (head_first) begin
            emit_item = mk_out(rd_data_r, 1'b1, 1'b0, ERR_NONE);
            pop       = 1'b1;
          end else begin
            emit_item = mk_out(cur.value, 1'b1, 1'b0, ERR_NONE);
          end
        end
      end
      ST_DRAIN_EMIT: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_item = mk_out(rd_data_r, 1'b1, drain_last_r && last_one, ERR_NONE);
          pop       = 1'b1;
          clear_all = drain_last_r && last_one;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_nxt  = count_r;
    head_nxt   = head_r;
    side_nxt   = side_r;
    a_done_nxt = a_done_r;
    b_done_nxt = b_done_r;
    if (store) begin
      count_nxt = count_r + 1'b1;
      side_nxt  = cur.side;
    end
    if (pop) begin
      count_nxt = count_r - 1'b1;
      head_nxt  = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (set_done) begin
      if (cur.side) b_done_nxt = 1'b1;
      else a_done_nxt = 1'b1;
    end
    if (clear_all) begin
      count_nxt  = '0;
      head_nxt   = '0;
      side_nxt   = 1'b0;
      a_done_nxt = 1'b0;
      b_done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      side_r      <= 1'b0;
      a_done_r    <= 1'b0;
      b_done_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      head_r   <= head_nxt;
      side_r   <= side_nxt;
      a_done_r <= a_done_nxt;
      b_done_r <= b_done_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd_r        <= cmd_i;
      drain_last_r <= d_last;
    end
    if (emit) begin
      out_r <= emit_item;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      mem[waddr] <= cur.value;
    end
    rd_data_r <= mem[head_r];
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("pending count above depth");

  a_cmp_opposite: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MERGE_CMP |-> !q_empty && side_r != cmd_r.side)
    else $error("merge compare without opposite held values");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    emit && emit_item.last |=> !a_done_r && !b_done_r && count_r == '0)
    else $error("merge state not cleared after last item");

  a_no_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !emit_item.has_value |-> emit_item.value_res == '0)
    else $error("item without value carries nonzero data");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> slot_free)
    else $error("item written over a waiting result");
`endif

endmodule

FILE: sv/two_way_sorted_merge_unit.sv
`timescale 1ns / 1ps

// Merges two ascending signed 32-bit streams A and B into one ascending stream; on
// equal values B goes first. The input side is a two-entry command queue that takes
// one item per cycle while it has room. The back end handles one item at a time. A push
// that is held, rejected or passed through, or an end that needs no drain, is done in
// the cycle in which the back end takes it. A push that meets held values of the other
// side then goes through a registered read of the store, then the compare, for each held
// value it releases. It finishes when the store runs empty, or when a compare sends the
// new value out ahead of the rest. An end that drains the store gives each held value a
// registered read of the store, then an emit, until the store is empty.
// Results leave through a one-entry output register, and the back end waits while that
// register is full and not being popped.
module two_way_sorted_merge_unit import tsm_pkg::*; #(
  parameter int QUEUE_DEPTH = TSM_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  tsm_in_t  in_item,
  output logic     out_empty,
  input  logic     out_pop,
  output tsm_out_t out_item
);

  tsm_cmd_t cmd;
  logic     cmd_valid;
  logic     cmd_take;

  tsm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cmd_o     (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take)
  );

  tsm_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
